// ===== hdl/dbdc_pkg.sv =====
package dbdc_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE       = 2'd0,
        OP_TAKE_TOGGLES = 2'd1,
        OP_TAKE_REQUEST = 2'd2,
        OP_PEEK         = 2'd3
    } op_t;

    localparam int unsigned ADDR_W = 3;

    typedef enum logic {
        REG_DEBOUNCE   = 1'b0,
        REG_CHORD_HOLD = 1'b1
    } reg_idx_t;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [15:0] CHORD_RESET    = 16'd3000;

    typedef struct packed {
        logic [1:0]  operation;
        logic        button_a_down;
        logic        button_b_down;
        logic [31:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic       press_a;
        logic       press_b;
        logic       stable_a;
        logic       stable_b;
        logic [1:0] toggle_mask;
        logic       setup_request;
    } result_t;

endpackage

// ===== hdl/dual_button_debounce_chord.sv =====
// channel   | handshake                         | payload
// ----------+-----------------------------------+-----------------------------
// sample    | sample_valid / sample_ready       | sample (sample_t)
// result    | result_valid / result_ready       | result (result_t)
// config    | psel penable pwrite pready (APB)  | paddr pwdata / prdata
//
// one item per cycle while sample_ready is high: the whole update is one pass of compare/subtract logic
// into the result register, with a one-entry skid register behind it
// sample_ready only drops while the skid register holds a result
// rst_n clears all button, chord and toggle state and reloads both timings
// no clearing pass; the block takes items from the first cycle after reset
module dual_button_debounce_chord
    import dbdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  sample_t           sample,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] debounce_reg;
    logic [15:0] chord_hold_reg;

    logic        raw_a_reg, raw_b_reg;
    logic        stable_a_reg, stable_b_reg;
    logic [31:0] changed_a_reg, changed_b_reg;
    logic        chord_active_reg;
    logic [31:0] chord_start_reg;
    logic        chord_fired_reg;
    logic        request_reg;
    logic [1:0]  toggles_reg;

    logic        raw_a_next, raw_b_next;
    logic        stable_a_next, stable_b_next;
    logic [31:0] changed_a_next, changed_b_next;
    logic        chord_active_next;
    logic [31:0] chord_start_next;
    logic        chord_fired_next;
    logic        request_next;
    logic [1:0]  toggles_next;

    logic        result_valid_reg, skid_valid_reg;
    result_t     result_reg, skid_reg;
    result_t     res;

    logic        accept;
    logic        cfg_write;
    logic        sampling;
    logic        press_a, press_b;
    logic [31:0] held_a, held_b, chord_time;
    logic [1:0]  mask_upd;
    logic        req_upd;

    assign accept    = sample_valid && sample_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign sampling  = (sample.operation == OP_SAMPLE);
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = 32'd0;
        unique case (reg_idx_t'(paddr[2]))
            REG_DEBOUNCE:   prdata = {16'd0, debounce_reg};
            REG_CHORD_HOLD: prdata = {16'd0, chord_hold_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        raw_a_next        = raw_a_reg;
        raw_b_next        = raw_b_reg;
        stable_a_next     = stable_a_reg;
        stable_b_next     = stable_b_reg;
        changed_a_next    = changed_a_reg;
        changed_b_next    = changed_b_reg;
        chord_active_next = chord_active_reg;
        chord_start_next  = chord_start_reg;
        chord_fired_next  = chord_fired_reg;
        press_a           = 1'b0;
        press_b           = 1'b0;
        mask_upd          = toggles_reg;
        req_upd           = request_reg;

        // a fresh raw change restarts the hold time at zero
        held_a = (sample.button_a_down != raw_a_reg) ? 32'd0
                                                     : sample.now_ms - changed_a_reg;
        held_b = (sample.button_b_down != raw_b_reg) ? 32'd0
                                                     : sample.now_ms - changed_b_reg;
        chord_time = chord_active_reg ? sample.now_ms - chord_start_reg : 32'd0;

        if (sampling)
        begin
            raw_a_next = sample.button_a_down;
            raw_b_next = sample.button_b_down;
            if (sample.button_a_down != raw_a_reg)
                changed_a_next = sample.now_ms;
            if (sample.button_b_down != raw_b_reg)
                changed_b_next = sample.now_ms;
            if (stable_a_reg != sample.button_a_down && held_a >= {16'd0, debounce_reg})
            begin
                stable_a_next = sample.button_a_down;
                press_a       = sample.button_a_down;
            end
            if (stable_b_reg != sample.button_b_down && held_b >= {16'd0, debounce_reg})
            begin
                stable_b_next = sample.button_b_down;
                press_b       = sample.button_b_down;
            end
            if (stable_a_next && stable_b_next)
            begin
                if (!chord_active_reg)
                begin
                    chord_active_next = 1'b1;
                    chord_start_next  = sample.now_ms;
                end
                if (!chord_fired_reg && chord_time >= {16'd0, chord_hold_reg})
                begin
                    chord_fired_next = 1'b1;
                    req_upd          = 1'b1;
                end
            end
            else
            begin
                chord_active_next = 1'b0;
                chord_fired_next  = 1'b0;
                mask_upd          = toggles_reg ^ {press_b, press_a};
            end
        end

        toggles_next = mask_upd;
        request_next = req_upd;
        case (sample.operation)
            OP_TAKE_TOGGLES: toggles_next = 2'd0;
            OP_TAKE_REQUEST: request_next = 1'b0;
            default:         ;
        endcase

        res.press_a       = press_a;
        res.press_b       = press_b;
        res.stable_a      = stable_a_next;
        res.stable_b      = stable_b_next;
        res.toggle_mask   = mask_upd;
        res.setup_request = req_upd;
    end

    assign sample_ready = !skid_valid_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= DEBOUNCE_RESET;
            chord_hold_reg   <= CHORD_RESET;
            raw_a_reg        <= 1'b0;
            raw_b_reg        <= 1'b0;
            stable_a_reg     <= 1'b0;
            stable_b_reg     <= 1'b0;
            changed_a_reg    <= 32'd0;
            changed_b_reg    <= 32'd0;
            chord_active_reg <= 1'b0;
            chord_start_reg  <= 32'd0;
            chord_fired_reg  <= 1'b0;
            request_reg      <= 1'b0;
            toggles_reg      <= 2'd0;
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (reg_idx_t'(paddr[2]))
                    REG_DEBOUNCE:   debounce_reg   <= pwdata[15:0];
                    REG_CHORD_HOLD: chord_hold_reg <= pwdata[15:0];
                    default:        ;
                endcase
            end
            if (accept)
            begin
                raw_a_reg        <= raw_a_next;
                raw_b_reg        <= raw_b_next;
                stable_a_reg     <= stable_a_next;
                stable_b_reg     <= stable_b_next;
                changed_a_reg    <= changed_a_next;
                changed_b_reg    <= changed_b_next;
                chord_active_reg <= chord_active_next;
                chord_start_reg  <= chord_start_next;
                chord_fired_reg  <= chord_fired_next;
                request_reg      <= request_next;
                toggles_reg      <= toggles_next;
            end
            // output register drains first, skid catches a transfer made while stalled
            if (!result_valid_reg || result_ready)
            begin
                if (skid_valid_reg)
                begin
                    result_valid_reg <= 1'b1;
                    skid_valid_reg   <= 1'b0;
                end
                else
                    result_valid_reg <= accept;
            end
            else if (accept)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!result_valid_reg || result_ready)
        begin
            if (skid_valid_reg)
                result_reg <= skid_reg;
            else if (accept)
                result_reg <= res;
        end
        else if (accept)
            skid_reg <= res;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid register holds a result ahead of the output register");

    a_press_is_down: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!result_reg.press_a || result_reg.stable_a)
                          && (!result_reg.press_b || result_reg.stable_b))
        else $error("press event without a stable down level");

    a_fired_in_chord: assert property (@(posedge clk) disable iff (!rst_n)
        chord_fired_reg |-> chord_active_reg && stable_a_reg && stable_b_reg)
        else $error("chord fired outside an active chord");

    a_request_from_chord: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(request_reg) |-> $rose(chord_fired_reg))
        else $error("setup request raised without the chord firing");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready |=> result_valid_reg && $stable(result_reg))
        else $error("stalled result changed");

endmodule
